>>> hw/rtl/adtf_pkg.sv
// ============================================================================
// adtf_pkg: shared types and constants for the ASCII decimal to float block
// Item and result layouts, the job passed from the parser to the scaler,
// state encodings, status codes and the single precision rounding helper.
// ============================================================================
package adtf_pkg;

  localparam int MAX_SIG_DIGITS_DEF = 9;
  localparam int EXP_LIMIT_DEF      = 1000;
  localparam int DEC_EXP_BITS_DEF   = 16;

  localparam int MANT_W    = 30;
  localparam int KEPT_W    = 4;
  localparam int EXP_ACC_W = 14;
  localparam int JOB_EXP_W = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LOWER_E = 8'h65;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_CLAMP   = 2'd2;

  localparam logic [30:0] MAX_MAG      = 31'h7F7FFFFF;
  localparam logic [30:0] MIN_NORM_MAG = 31'h00800000;
  localparam logic [30:0] MUL_LIM_MAG  = 31'h7DCCCCCC;
  localparam logic [31:0] RECIP_TEN    = 32'hCCCCCCCD;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [31:0] value_bits;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic                        invalid;
    logic                        neg;
    logic [MANT_W-1:0]           mant;
    logic signed [JOB_EXP_W-1:0] dexp;
  } job_t;

  typedef enum logic [2:0] {
    PH_START, PH_MANT, PH_EXP_START, PH_EXP_NEED, PH_EXP_DIGITS, PH_ENDED, PH_INVALID
  } phase_t;

  typedef enum logic [2:0] {
    B_IDLE, B_NORM, B_CONV, B_SCALE, B_DIV, B_DONE
  } bstate_t;

  // Shifts val right by sh (at most six), rounds to nearest even and packs the
  // magnitude; base is the biased exponent less one, the hidden bit adds the one.
  function automatic logic [30:0] round_pack(input logic [29:0] val, input logic [3:0] sh,
                                             input logic [7:0] base, input logic rem_nz);
    logic [29:0] smask;
    logic        gbit;
    logic        sticky;
    logic [23:0] m;
    logic        up;
    gbit   = (sh != 4'd0) ? val[sh - 4'd1] : 1'b0;
    smask  = (sh > 4'd1) ? ~({30{1'b1}} << (sh - 4'd1)) : '0;
    sticky = (|(val & smask)) | rem_nz;
    m      = 24'(val >> sh);
    up     = gbit & (sticky | m[0]);
    return {base, 23'b0} + 31'(m) + 31'(up);
  endfunction

endpackage

>>> hw/rtl/adtf_front.sv
// ============================================================================
// adtf_front: character parser
// Takes one character a cycle while the queue has room, tracks sign, kept
// digits and exponents, and on the final character hands a finished job to the queue.
// ============================================================================
module adtf_front #(
  parameter int MAX_SIG_DIGITS = adtf_pkg::MAX_SIG_DIGITS_DEF,
  parameter int EXP_LIMIT      = adtf_pkg::EXP_LIMIT_DEF,
  parameter int DEC_EXP_BITS   = adtf_pkg::DEC_EXP_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  adtf_pkg::item_t item,
  input  logic            take,
  output adtf_pkg::job_t  job,
  output logic            job_push
);
  import adtf_pkg::*;

  localparam int SW = ((DEC_EXP_BITS > EXP_ACC_W) ? DEC_EXP_BITS : EXP_ACC_W) + 2;
  localparam logic signed [DEC_EXP_BITS-1:0] DMAX = {1'b0, {(DEC_EXP_BITS-1){1'b1}}};
  localparam logic signed [DEC_EXP_BITS-1:0] DMIN = {1'b1, {(DEC_EXP_BITS-1){1'b0}}};

  phase_t                          phase, phase_next;
  logic                            neg, neg_next;
  logic [MANT_W-1:0]               mant, mant_next;
  logic [KEPT_W-1:0]               kept, kept_next;
  logic                            point, point_next;
  logic                            digit, digit_next;
  logic                            sig, sig_next;
  logic                            exp_neg, exp_neg_next;
  logic [EXP_ACC_W-1:0]            exp_acc, exp_acc_next;
  logic signed [DEC_EXP_BITS-1:0]  dec, dec_next;

  logic                            is_dig, is_term, mant_step, exp_step;
  logic [3:0]                      d;
  logic signed [DEC_EXP_BITS-1:0]  dec_dn, dec_up;
  logic signed [SW-1:0]            esum, eadd;
  logic signed [DEC_EXP_BITS-1:0]  e_cl;

  always_comb begin
    is_dig  = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
    is_term = (item.ch == CH_NUL) || (item.ch == CH_LF) || (item.ch == CH_CR);
    d       = 4'(item.ch - CH_ZERO);
    dec_dn  = (dec == DMIN) ? dec : dec - DEC_EXP_BITS'(1);
    dec_up  = (dec == DMAX) ? dec : dec + DEC_EXP_BITS'(1);

    phase_next   = phase;
    neg_next     = neg;
    mant_next    = mant;
    kept_next    = kept;
    point_next   = point;
    digit_next   = digit;
    sig_next     = sig;
    exp_neg_next = exp_neg;
    exp_acc_next = exp_acc;
    dec_next     = dec;
    mant_step    = 1'b0;
    exp_step     = 1'b0;

    unique case (phase)
      PH_START: begin
        if (item.ch == CH_PLUS || item.ch == CH_MINUS) begin
          neg_next   = (item.ch == CH_MINUS);
          phase_next = PH_MANT;
        end else begin
          mant_step = 1'b1;
        end
      end
      PH_MANT: mant_step = 1'b1;
      PH_EXP_START: begin
        if (item.ch == CH_PLUS || item.ch == CH_MINUS) begin
          exp_neg_next = (item.ch == CH_MINUS);
          phase_next   = PH_EXP_NEED;
        end else if (is_dig) begin
          exp_step = 1'b1;
        end else begin
          phase_next = PH_INVALID;
        end
      end
      PH_EXP_NEED: begin
        if (is_dig) begin
          exp_step = 1'b1;
        end else begin
          phase_next = PH_INVALID;
        end
      end
      PH_EXP_DIGITS: begin
        if (is_dig) begin
          exp_step = 1'b1;
        end else begin
          phase_next = is_term ? PH_ENDED : PH_INVALID;
        end
      end
      PH_ENDED, PH_INVALID: ;
      default: ;
    endcase

    if (mant_step) begin
      if (is_dig) begin
        digit_next = 1'b1;
        if (!sig && d == 4'd0) begin
          if (point) begin
            dec_next = dec_dn;
          end
        end else begin
          sig_next = 1'b1;
          if (kept < KEPT_W'(MAX_SIG_DIGITS)) begin
            mant_next = MANT_W'(mant * MANT_W'(10) + MANT_W'(d));
            kept_next = kept + KEPT_W'(1);
            if (point) begin
              dec_next = dec_dn;
            end
          end else if (!point) begin
            dec_next = dec_up;
          end
        end
        phase_next = PH_MANT;
      end else if (item.ch == CH_DOT) begin
        phase_next = point ? PH_INVALID : PH_MANT;
        point_next = 1'b1;
      end else if (item.ch == CH_LOWER_E || item.ch == CH_UPPER_E) begin
        phase_next = digit ? PH_EXP_START : PH_INVALID;
      end else if (is_term) begin
        phase_next = PH_ENDED;
      end else begin
        phase_next = PH_INVALID;
      end
    end

    if (exp_step) begin
      if (exp_acc < EXP_ACC_W'(EXP_LIMIT)) begin
        exp_acc_next = EXP_ACC_W'(exp_acc * EXP_ACC_W'(10) + EXP_ACC_W'(d));
      end
      phase_next = PH_EXP_DIGITS;
    end

    eadd = signed'(SW'(exp_acc_next));
    esum = SW'(dec_next) + (exp_neg_next ? -eadd : eadd);
    if (esum > SW'(DMAX)) begin
      e_cl = DMAX;
    end else if (esum < SW'(DMIN)) begin
      e_cl = DMIN;
    end else begin
      e_cl = DEC_EXP_BITS'(esum);
    end

    job.invalid = (phase_next == PH_INVALID) || (phase_next == PH_START) ||
                  (phase_next == PH_EXP_START) || (phase_next == PH_EXP_NEED) || !digit_next;
    job.neg     = neg_next;
    job.mant    = mant_next;
    job.dexp    = JOB_EXP_W'(e_cl);
    job_push    = take & item.last;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.last)) begin
      phase   <= PH_START;
      neg     <= 1'b0;
      mant    <= '0;
      kept    <= '0;
      point   <= 1'b0;
      digit   <= 1'b0;
      sig     <= 1'b0;
      exp_neg <= 1'b0;
      exp_acc <= '0;
      dec     <= '0;
    end else if (take) begin
      phase   <= phase_next;
      neg     <= neg_next;
      mant    <= mant_next;
      kept    <= kept_next;
      point   <= point_next;
      digit   <= digit_next;
      sig     <= sig_next;
      exp_neg <= exp_neg_next;
      exp_acc <= exp_acc_next;
      dec     <= dec_next;
    end
  end

endmodule

>>> hw/rtl/adtf_queue.sv
// ============================================================================
// adtf_queue: two-entry job queue
// Decouples the parser from the scaler so that each side stalls on its own.
// ============================================================================
module adtf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  adtf_pkg::job_t wr_job,
  output logic           q_full,
  input  logic           rd,
  output adtf_pkg::job_t rd_job,
  output logic           q_empty
);
  import adtf_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_job  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr && !q_full) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr && !q_full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd && !q_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(wr && !q_full) - 2'(rd && !q_empty);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst) !(wr && q_full))
    else $error("job written into a full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) !(rd && q_empty))
    else $error("job read from an empty queue");

endmodule

>>> hw/rtl/adtf_back.sv
// ============================================================================
// adtf_back: significand conversion and decimal scaling
// Normalises the kept significand, rounds it to single precision, then steps
// it by ten per unit of decimal exponent and holds the result for the reader.
// ============================================================================
module adtf_back #(
  parameter int DEC_EXP_BITS = adtf_pkg::DEC_EXP_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  adtf_pkg::job_t    job,
  input  logic              q_empty,
  output logic              q_pop,
  output adtf_pkg::result_t result,
  output logic              empty,
  input  logic              pop
);
  import adtf_pkg::*;

  bstate_t                        state, state_next;
  logic                           neg;
  logic signed [DEC_EXP_BITS-1:0] e;
  logic [MANT_W-1:0]              nacc;
  logic [4:0]                     k;
  logic [30:0]                    r;
  logic [60:0]                    prod;
  logic [31:0]                    res_bits;
  logic [1:0]                     res_status;
  result_t                        out_res;
  logic                           out_valid;

  logic [7:0]  field, feff;
  logic [23:0] m;
  logic        rnz, e_pos, e_neg;
  logic        go_ovf, go_mul, go_div, go_fin, out_load;
  logic [27:0] p;
  logic [3:0]  msh, dsh, s;
  logic [30:0] r_mul, r_div, r_conv;
  logic [28:0] x;
  logic [25:0] q;
  logic        rem_nz;
  logic signed [9:0] bs;
  logic [7:0]  dbase;

  always_comb begin
    field = r[30:23];
    m     = {field != 8'd0, r[22:0]};
    feff  = (field != 8'd0) ? field : 8'd1;
    rnz   = (r != 31'd0);
    e_pos = (e > 0);
    e_neg = (e < 0);

    p = 28'({m, 3'b0}) + 28'({m, 1'b0});
    priority if (p[27]) msh = 4'd4;
    else if (p[26])     msh = 4'd3;
    else if (p[25])     msh = 4'd2;
    else if (p[24])     msh = 4'd1;
    else                msh = 4'd0;
    r_mul = round_pack(30'(p), msh, feff - 8'd1 + 8'(msh), 1'b0);

    x      = {m, 5'b0};
    q      = prod[60:35];
    rem_nz = (x != (29'({q, 3'b0}) + 29'({q, 1'b0})));
    s      = q[25] ? 4'd2 : 4'd1;
    bs     = signed'(10'(feff)) - 10'sd6 + signed'(10'(s));
    if (field == 8'd0) begin
      dsh   = 4'd5;
      dbase = 8'd0;
    end else if (bs < 0) begin
      dsh   = 4'(10'(s) - 10'(bs));
      dbase = 8'd0;
    end else begin
      dsh   = s;
      dbase = 8'(bs);
    end
    r_div = round_pack(30'(q), dsh, dbase, rem_nz);

    r_conv = round_pack(nacc, 4'd6, 8'd155 - 8'(k), 1'b0);

    go_ovf   = e_pos && rnz && (r > MUL_LIM_MAG);
    go_mul   = e_pos && rnz && !(r > MUL_LIM_MAG);
    go_div   = !e_pos && e_neg && rnz;
    go_fin   = !(e_pos && rnz) && !(e_neg && rnz);
    out_load = (state == B_DONE) && (!out_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = job.invalid ? B_DONE : B_NORM;
        end
      end
      B_NORM: begin
        if (nacc == '0) begin
          state_next = B_SCALE;
        end else if (nacc[MANT_W-1]) begin
          state_next = B_CONV;
        end
      end
      B_CONV: state_next = B_SCALE;
      B_SCALE: begin
        if (go_ovf || go_fin) begin
          state_next = B_DONE;
        end else if (go_div) begin
          state_next = B_DIV;
        end
      end
      B_DIV: state_next = B_SCALE;
      B_DONE: begin
        if (!out_valid || pop) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          neg        <= job.neg;
          e          <= DEC_EXP_BITS'(job.dexp);
          nacc       <= job.mant;
          k          <= 5'd0;
          r          <= '0;
          res_bits   <= '0;
          res_status <= ST_INVALID;
        end
      end
      B_NORM: begin
        if (nacc != '0 && !nacc[MANT_W-1]) begin
          nacc <= nacc << 1;
          k    <= k + 5'd1;
        end
      end
      B_CONV: r <= r_conv;
      B_SCALE: begin
        if (go_ovf) begin
          res_bits   <= {neg, MAX_MAG};
          res_status <= ST_CLAMP;
        end else if (go_mul) begin
          r <= r_mul;
          e <= e - DEC_EXP_BITS'(1);
        end else if (go_div) begin
          prod <= 61'(x) * 61'(RECIP_TEN);
        end else if (rnz && field == 8'd0) begin
          res_bits   <= {neg, MIN_NORM_MAG};
          res_status <= ST_CLAMP;
        end else begin
          res_bits   <= {neg, r};
          res_status <= ST_OK;
        end
      end
      B_DIV: begin
        r <= r_div;
        e <= e + DEC_EXP_BITS'(1);
      end
      B_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res.value_bits <= res_bits;
      out_res.status     <= res_status;
    end
  end

  assign result = out_res;
  assign empty  = !out_valid;

  a_div_from_scale: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> ($past(state) == B_SCALE))
    else $error("divide step entered without a scaling decision");
  a_zero_finishes: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCALE && r == 31'd0) |=> (state == B_DONE))
    else $error("zero significand kept scaling");
  a_norm_counts: assert property (@(posedge clk) disable iff (rst)
    (state == B_NORM && nacc != '0 && !nacc[MANT_W-1]) |=> (k == $past(k) + 5'd1))
    else $error("normalisation shift not counted");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("finished result not presented");

endmodule

>>> hw/rtl/ascii_decimal_to_float_single_core.sv
// ============================================================================
// ascii_decimal_to_float_single_core: ASCII decimal text to IEEE single
// Parses a decimal number one character per beat and returns its single
// precision bits with a status on the final character.
// ============================================================================
// The input channel takes one character per beat while full is low; last
// marks the final character of a number. Nothing is returned for other beats.
// Each number yields one result beat on the output queue interface: the
// oldest result sits on result while empty is low and leaves on pop.
// The parser takes a character every cycle while full is low. The scaler
// then normalises the kept significand, rounds it to single precision,
// multiplies by ten once per unit of positive decimal exponent and divides
// by ten once per unit of negative exponent (through the reciprocal
// multiplier, then a rounding step), and hands the result over, stopping
// early once the value would overflow or has rounded to zero.
// A two-entry job queue lets the parser run ahead on following numbers.
// Reset clears the parser, queue and scaler and empties the output.
// When the reader stalls, the finished result waits and the scaler, then the
// queue and finally the input side (full) hold.
module ascii_decimal_to_float_single_core #(
  parameter int MAX_SIG_DIGITS = adtf_pkg::MAX_SIG_DIGITS_DEF,
  parameter int EXP_LIMIT      = adtf_pkg::EXP_LIMIT_DEF,
  parameter int DEC_EXP_BITS   = adtf_pkg::DEC_EXP_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  adtf_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output adtf_pkg::result_t result
);
  import adtf_pkg::*;

  job_t front_job;
  job_t queue_job;
  logic job_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign full = q_full;

  adtf_front #(
    .MAX_SIG_DIGITS (MAX_SIG_DIGITS),
    .EXP_LIMIT      (EXP_LIMIT),
    .DEC_EXP_BITS   (DEC_EXP_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .take     (push && !q_full),
    .job      (front_job),
    .job_push (job_push)
  );

  adtf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .wr_job  (front_job),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_job  (queue_job),
    .q_empty (q_empty)
  );

  adtf_back #(
    .DEC_EXP_BITS (DEC_EXP_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .job     (queue_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
